// File: sv/mf3_pkg.sv
// Shared types and constants for the 3x3 RGB median filter.
// No dependencies; imported by every module of the block.
`default_nettype none

package mf3_pkg;

  // Frame geometry limits.
  localparam int MAX_WIDTH  = 2048;
  localparam int MAX_HEIGHT = 4096;
  localparam int ADDR_W     = $clog2(MAX_WIDTH);
  localparam int COL_W      = 11;
  localparam int ROW_W      = 12;
  localparam int WIDTH_W    = 12;
  localparam int HEIGHT_W   = 13;

  // Configuration port.
  localparam int CFG_INDEX_W = 8;
  localparam int CFG_DATA_W  = 16;
  localparam logic [CFG_INDEX_W-1:0] REG_IMAGE_WIDTH  = 8'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_IMAGE_HEIGHT = 8'd1;

  localparam logic [WIDTH_W-1:0]  WIDTH_MIN  = 12'd3;
  localparam logic [WIDTH_W-1:0]  WIDTH_MAX  = 12'd2048;
  localparam logic [WIDTH_W-1:0]  WIDTH_RST  = 12'd640;
  localparam logic [HEIGHT_W-1:0] HEIGHT_MIN = 13'd3;
  localparam logic [HEIGHT_W-1:0] HEIGHT_MAX = 13'd4096;
  localparam logic [HEIGHT_W-1:0] HEIGHT_RST = 13'd480;

  // One RGB pixel, channel k in element k.
  typedef logic [2:0][7:0] rgb_t;

  // Nine 8-bit window values of one channel.
  typedef logic [8:0][7:0] win9_t;

  // Input beat.
  typedef struct packed {
    logic [7:0] pixel_ch0;
    logic [7:0] pixel_ch1;
    logic [7:0] pixel_ch2;
  } pixel_t;

  // Output beat.
  typedef struct packed {
    logic [7:0]       med_ch0;
    logic [7:0]       med_ch1;
    logic [7:0]       med_ch2;
    logic [COL_W-1:0] center_col;
    logic [ROW_W-1:0] center_row;
    logic             frame_last;
  } result_t;

  // Position information that travels beside the median lanes.
  typedef struct packed {
    logic [COL_W-1:0] center_col;
    logic [ROW_W-1:0] center_row;
    logic             frame_last;
  } meta_t;

endpackage

`default_nettype wire

// File: sv/median_filter_3x3_rgb.sv
// Top level of the 3x3 RGB median filter.
// Depends on mf3_pkg, mf3_linebuf, mf3_lane and mf3_merge.
`default_nettype none

// Streams raster RGB pixels and returns, for every interior pixel, the
// per-channel median of its 3x3 neighborhood with the center position and a
// last-of-frame flag; border pixels give no beat. One pixel is accepted per
// clock while the output side takes beats; the pipeline holds whenever the
// output register is full and not taken. After the pixel that completes its
// window is accepted, its result passes through the line store read at the
// accepting edge, then the window shift, the register stages of the sorting
// network and the output register. The line stores need no clearing pass
// after reset, so pixels are accepted from the first cycle out of reset. A
// write of either geometry register restarts the frame at column zero, row
// zero; out-of-range sizes are clamped to the supported limits, after the
// data is cut to 12 bits for width and 13 bits for height.

module median_filter_3x3_rgb
  import mf3_pkg::*;
(
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   in_valid,
  output logic                        in_ready,
  input  wire pixel_t                 in_data,
  output logic                        out_valid,
  input  wire logic                   out_ready,
  output result_t                     out_data,
  input  wire logic                   cfg_valid,
  output logic                        cfg_ready,
  input  wire logic [CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [CFG_DATA_W-1:0]  cfg_data
);

  logic [WIDTH_W-1:0]  img_width;
  logic [HEIGHT_W-1:0] img_height;
  logic [COL_W-1:0]    col;
  logic [ROW_W-1:0]    row;

  logic                adv;
  logic                accept;
  logic                cfg_wr;
  logic [WIDTH_W-1:0]  width_raw;
  logic [HEIGHT_W-1:0] height_raw;
  logic [WIDTH_W-1:0]  col_inc;
  logic [HEIGHT_W-1:0] row_inc;
  logic                line_end;
  logic                frame_end;
  rgb_t                in_pix;

  logic                s1_valid;
  logic                s1_has;
  logic [ADDR_W-1:0]   s1_addr;
  rgb_t                s1_pix;
  meta_t               s1_meta;
  rgb_t                up2;
  rgb_t                up1;

  rgb_t                window [9];
  logic                v2;
  logic                v3;
  logic                v4;
  logic                v5;
  meta_t               meta2;
  meta_t               meta3;
  meta_t               meta4;
  meta_t               meta5;
  rgb_t                med;

  // The whole pipeline moves together unless the output beat is held.
  assign adv       = !out_valid || out_ready;
  assign in_ready  = adv;
  assign accept    = in_valid && adv;
  assign cfg_ready = 1'b1;
  assign cfg_wr    = cfg_valid && cfg_ready;

  assign in_pix = {in_data.pixel_ch2, in_data.pixel_ch1, in_data.pixel_ch0};

  // Geometry registers, stored already clamped.
  assign width_raw  = cfg_data[WIDTH_W-1:0];
  assign height_raw = cfg_data[HEIGHT_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      img_width  <= WIDTH_RST;
      img_height <= HEIGHT_RST;
    end else if (cfg_wr) begin
      case (cfg_index)
        REG_IMAGE_WIDTH: begin
          if (width_raw < WIDTH_MIN) begin
            img_width <= WIDTH_MIN;
          end else if (width_raw > WIDTH_MAX) begin
            img_width <= WIDTH_MAX;
          end else begin
            img_width <= width_raw;
          end
        end
        REG_IMAGE_HEIGHT: begin
          if (height_raw < HEIGHT_MIN) begin
            img_height <= HEIGHT_MIN;
          end else if (height_raw > HEIGHT_MAX) begin
            img_height <= HEIGHT_MAX;
          end else begin
            img_height <= height_raw;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // Raster position of the next pixel.
  assign col_inc   = {1'b0, col} + 12'd1;
  assign row_inc   = {1'b0, row} + 13'd1;
  assign line_end  = col_inc >= img_width;
  assign frame_end = row_inc >= img_height;

  always_ff @(posedge clk) begin
    if (rst) begin
      col <= '0;
      row <= '0;
    end else if (cfg_wr && (cfg_index == REG_IMAGE_WIDTH || cfg_index == REG_IMAGE_HEIGHT)) begin
      col <= '0;
      row <= '0;
    end else if (accept) begin
      if (line_end) begin
        col <= '0;
        row <= frame_end ? '0 : row_inc[ROW_W-1:0];
      end else begin
        col <= col_inc[COL_W-1:0];
      end
    end
  end

  // Stage one: pixel and position wait for the line store read.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (adv) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_has             <= (col >= 11'd2) && (row >= 12'd2);
      s1_addr            <= col[ADDR_W-1:0];
      s1_pix             <= in_pix;
      s1_meta.center_col <= col - 11'd1;
      s1_meta.center_row <= row - 12'd1;
      s1_meta.frame_last <= line_end && frame_end;
    end
  end

  mf3_linebuf u_linebuf (
    .clk     (clk),
    .rd_en   (accept),
    .rd_addr (col[ADDR_W-1:0]),
    .wr_en   (adv && s1_valid),
    .wr_addr (s1_addr),
    .wr_pix  (s1_pix),
    .up2     (up2),
    .up1     (up1)
  );

  // Stage two: the window shifts left and takes the new column.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 9; i++) begin
        window[i] <= '0;
      end
    end else if (adv && s1_valid) begin
      for (int k = 0; k < 3; k++) begin
        window[k*3]   <= window[k*3+1];
        window[k*3+1] <= window[k*3+2];
      end
      window[2] <= up2;
      window[5] <= up1;
      window[8] <= s1_pix;
    end
  end

  // Valid flags and position data beside the sorting lanes.
  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      v5 <= 1'b0;
    end else if (adv) begin
      v2 <= s1_valid && s1_has;
      v3 <= v2;
      v4 <= v3;
      v5 <= v4;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      meta2 <= s1_meta;
      meta3 <= meta2;
      meta4 <= meta3;
      meta5 <= meta4;
    end
  end

  // One sorting lane per color channel.
  for (genvar ch = 0; ch < 3; ch++) begin : g_lane
    win9_t lane_win;

    always_comb begin
      for (int i = 0; i < 9; i++) begin
        lane_win[i] = window[i][ch];
      end
    end

    mf3_lane u_lane (
      .clk (clk),
      .en  (adv),
      .win (lane_win),
      .med (med[ch])
    );
  end

  mf3_merge u_merge (
    .clk       (clk),
    .rst       (rst),
    .en        (adv),
    .in_valid  (v5),
    .meta      (meta5),
    .med       (med),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire

// File: sv/mf3_linebuf.sv
// Two line stores of one raster line each, with registered reads.
// Depends on mf3_pkg.
`default_nettype none

module mf3_linebuf
  import mf3_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rd_en,
  input  wire logic [ADDR_W-1:0] rd_addr,
  input  wire logic              wr_en,
  input  wire logic [ADDR_W-1:0] wr_addr,
  input  wire rgb_t              wr_pix,
  output rgb_t                   up2,
  output rgb_t                   up1
);

  rgb_t older_mem [MAX_WIDTH];
  rgb_t newer_mem [MAX_WIDTH];

  // Read both lines at the column of the accepted pixel; data holds while stalled.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      up2 <= older_mem[rd_addr];
      up1 <= newer_mem[rd_addr];
    end
  end

  // The newer line moves down to the older store and the pixel takes its place.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      older_mem[wr_addr] <= up1;
      newer_mem[wr_addr] <= wr_pix;
    end
  end

endmodule

`default_nettype wire

// File: sv/mf3_lane.sv
// Median-of-nine sorting network for one color channel, three register stages.
// Depends on mf3_pkg.
`default_nettype none

module mf3_lane
  import mf3_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       en,
  input  wire win9_t      win,
  output logic [7:0]      med
);

  // Compare-exchange: the smaller value ends up at index a.
  function automatic win9_t ce(win9_t v, logic [3:0] a, logic [3:0] b);
    win9_t t;
    t = v;
    if (v[a] > v[b]) begin
      t[a] = v[b];
      t[b] = v[a];
    end
    return t;
  endfunction

  win9_t st_a;
  win9_t st_b;
  win9_t st_c;
  win9_t st_a_next;
  win9_t st_b_next;
  win9_t st_c_next;
  win9_t fin;

  // Stage A: sort the rows' pairs.
  always_comb begin
    st_a_next = win;
    st_a_next = ce(st_a_next, 4'd1, 4'd2);
    st_a_next = ce(st_a_next, 4'd4, 4'd5);
    st_a_next = ce(st_a_next, 4'd7, 4'd8);
    st_a_next = ce(st_a_next, 4'd0, 4'd1);
    st_a_next = ce(st_a_next, 4'd3, 4'd4);
    st_a_next = ce(st_a_next, 4'd6, 4'd7);
  end

  // Stage B: finish row sorts and start the column merge.
  always_comb begin
    st_b_next = st_a;
    st_b_next = ce(st_b_next, 4'd1, 4'd2);
    st_b_next = ce(st_b_next, 4'd4, 4'd5);
    st_b_next = ce(st_b_next, 4'd7, 4'd8);
    st_b_next = ce(st_b_next, 4'd0, 4'd3);
    st_b_next = ce(st_b_next, 4'd5, 4'd8);
    st_b_next = ce(st_b_next, 4'd4, 4'd7);
  end

  // Stage C: narrow the candidates around the middle.
  always_comb begin
    st_c_next = st_b;
    st_c_next = ce(st_c_next, 4'd3, 4'd6);
    st_c_next = ce(st_c_next, 4'd1, 4'd4);
    st_c_next = ce(st_c_next, 4'd2, 4'd5);
    st_c_next = ce(st_c_next, 4'd4, 4'd7);
  end

  // Final exchanges leave the median at index four.
  always_comb begin
    fin = st_c;
    fin = ce(fin, 4'd4, 4'd2);
    fin = ce(fin, 4'd6, 4'd4);
    fin = ce(fin, 4'd4, 4'd2);
  end

  assign med = fin[4];

  always_ff @(posedge clk) begin
    if (en) begin
      st_a <= st_a_next;
      st_b <= st_b_next;
      st_c <= st_c_next;
    end
  end

endmodule

`default_nettype wire

// File: sv/mf3_merge.sv
// Output stage: joins the three channel medians with the position data.
// Depends on mf3_pkg.
`default_nettype none

module mf3_merge
  import mf3_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    en,
  input  wire logic    in_valid,
  input  wire meta_t   meta,
  input  wire rgb_t    med,
  output logic         out_valid,
  output result_t      out_data
);

  // Output valid flag follows the pipeline whenever it advances.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= in_valid;
    end
  end

  // Output beat register.
  always_ff @(posedge clk) begin
    if (en) begin
      out_data.med_ch0    <= med[0];
      out_data.med_ch1    <= med[1];
      out_data.med_ch2    <= med[2];
      out_data.center_col <= meta.center_col;
      out_data.center_row <= meta.center_row;
      out_data.frame_last <= meta.frame_last;
    end
  end

endmodule

`default_nettype wire
